// ----- sv/utf8_byte_stream_decoder_core_macros.svh -----
// Assertion macros shared by the UTF-8 byte stream decoder.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UBSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubsd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define UBSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubsd: next-cycle check failed");

`endif

// ----- sv/ubsd_pkg.sv -----
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; all other files but the macro header use its scoped names.
package ubsd_pkg;

  localparam int unsigned CpWidth = 31;

  typedef enum logic [1:0] {
    KIND_CODE    = 2'd0,
    KIND_INVALID = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  // One queue entry describes every result caused by one byte. When two is
  // set, an invalid result with last clear goes out first, then kind/cp.
  typedef struct packed {
    logic               two;
    kind_t              kind;
    logic [CpWidth-1:0] cp;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

// ----- sv/ubsd_if.sv -----
// Handshake channels of the UTF-8 byte stream decoder: raw bytes in, results out.
// Depends on ubsd_pkg.
interface ubsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface ubsd_result_if;
  logic                         valid;
  logic                         ready;
  ubsd_pkg::kind_t              kind;
  logic [ubsd_pkg::CpWidth-1:0] code_point;
  logic                         last;

  modport source (output valid, output kind, output code_point, output last, input ready);
  modport sink (input valid, input kind, input code_point, input last, output ready);
endinterface

// ----- sv/ubsd_front.sv -----
// Front end: accepts bytes, tracks the sequence state and classifies each byte.
// Depends on ubsd_pkg and ubsd_byte_if.
module ubsd_front (
  input  logic                clk,
  input  logic                rst,
  ubsd_byte_if.sink           byte_chan,
  input  logic                full,
  output ubsd_pkg::push_t     push
);

  logic [2:0]                   bytes_left;
  logic [2:0]                   bytes_left_next;
  logic [ubsd_pkg::CpWidth-1:0] partial_value;
  logic [ubsd_pkg::CpWidth-1:0] partial_value_next;

  logic                         accept;
  logic [7:0]                   b;
  logic [2:0]                   ones;
  logic [6:0]                   lead_mask;
  logic [ubsd_pkg::CpWidth-1:0] pv_lead;
  logic [ubsd_pkg::CpWidth-1:0] pv_shift;
  logic                         idle_emit;
  logic                         idle_lead;
  ubsd_pkg::kind_t              idle_kind;
  logic [ubsd_pkg::CpWidth-1:0] idle_cp;
  logic                         emit;

  assign b               = byte_chan.in_byte;
  assign byte_chan.ready = !full;
  assign accept          = byte_chan.valid && !full;

  // Count of leading ones; seven stands for seven or eight.
  always_comb begin
    casez (b)
      8'b0???????: ones = 3'd0;
      8'b10??????: ones = 3'd1;
      8'b110?????: ones = 3'd2;
      8'b1110????: ones = 3'd3;
      8'b11110???: ones = 3'd4;
      8'b111110??: ones = 3'd5;
      8'b1111110?: ones = 3'd6;
      default:     ones = 3'd7;
    endcase
  end

  always_comb begin
    case (ones)
      3'd2:    lead_mask = 7'h1F;
      3'd3:    lead_mask = 7'h0F;
      3'd4:    lead_mask = 7'h07;
      3'd5:    lead_mask = 7'h03;
      3'd6:    lead_mask = 7'h01;
      default: lead_mask = 7'h00;
    endcase
  end

  assign pv_lead  = ubsd_pkg::CpWidth'(b[6:0] & lead_mask);
  assign pv_shift = {partial_value[ubsd_pkg::CpWidth-7:0], b[5:0]};

  // Treatment of the byte as if no sequence were open.
  always_comb begin
    idle_emit = 1'b1;
    idle_lead = 1'b0;
    idle_kind = ubsd_pkg::KIND_INVALID;
    idle_cp   = '0;
    if (b == 8'd0) begin
      idle_kind = ubsd_pkg::KIND_END;
    end else if (ones == 3'd0) begin
      idle_kind = ubsd_pkg::KIND_CODE;
      idle_cp   = ubsd_pkg::CpWidth'(b);
    end else if (ones != 3'd1 && ones != 3'd7) begin
      idle_emit = 1'b0;
      idle_lead = 1'b1;
    end
  end

  always_comb begin
    emit               = 1'b0;
    push.entry.two     = 1'b0;
    push.entry.kind    = idle_kind;
    push.entry.cp      = idle_cp;
    bytes_left_next    = bytes_left;
    partial_value_next = partial_value;
    if (bytes_left == 3'd0) begin
      emit = idle_emit;
      if (idle_lead) begin
        bytes_left_next    = ones - 3'd1;
        partial_value_next = pv_lead;
      end
    end else if (b == 8'd0) begin
      emit               = 1'b1;
      push.entry.two     = 1'b1;
      push.entry.kind    = ubsd_pkg::KIND_END;
      push.entry.cp      = '0;
      bytes_left_next    = 3'd0;
      partial_value_next = '0;
    end else if (b[7:6] == 2'b10) begin
      bytes_left_next    = bytes_left - 3'd1;
      partial_value_next = pv_shift;
      if (bytes_left == 3'd1) begin
        emit               = 1'b1;
        push.entry.kind    = ubsd_pkg::KIND_CODE;
        push.entry.cp      = pv_shift;
        partial_value_next = '0;
      end
    end else begin
      // Broken sequence: report it, then treat the byte as a fresh one.
      emit = 1'b1;
      if (idle_emit) begin
        push.entry.two = 1'b1;
      end else begin
        push.entry.kind = ubsd_pkg::KIND_INVALID;
        push.entry.cp   = '0;
      end
      bytes_left_next    = idle_lead ? ones - 3'd1 : 3'd0;
      partial_value_next = idle_lead ? pv_lead : '0;
    end
    push.valid = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= 3'd0;
      partial_value <= '0;
    end else if (accept) begin
      bytes_left    <= bytes_left_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

// ----- sv/ubsd_queue.sv -----
// Two-entry queue of result descriptors between the front and back ends.
// Depends on ubsd_pkg.
module ubsd_queue (
  input  logic             clk,
  input  logic             rst,
  input  ubsd_pkg::push_t  push,
  input  logic             pop,
  output ubsd_pkg::entry_t head,
  output logic             head_valid,
  output logic             full
);

  ubsd_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [1:0]       count_next;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + 2'd1;
    end else if (!push.valid && pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

// ----- sv/ubsd_back.sv -----
// Back end: expands each queued descriptor into one or two result items.
// Depends on ubsd_pkg and ubsd_result_if.
module ubsd_back (
  input  logic             clk,
  input  logic             rst,
  input  ubsd_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  ubsd_result_if.source    result_chan
);

  // Set once the leading invalid item of a two-item descriptor has gone.
  logic phase;
  logic first_of_two;
  logic taken;

  assign first_of_two = head.two && !phase;
  assign taken        = result_chan.valid && result_chan.ready;
  assign pop          = taken && !first_of_two;

  assign result_chan.valid      = head_valid;
  assign result_chan.kind       = first_of_two ? ubsd_pkg::KIND_INVALID : head.kind;
  assign result_chan.code_point = first_of_two ? '0 : head.cp;
  assign result_chan.last       = !first_of_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (taken) begin
      phase <= first_of_two;
    end
  end

endmodule

// ----- sv/utf8_byte_stream_decoder_core.sv -----
// UTF-8 byte stream decoder, older six-byte form. One raw byte enters per
// item on byte_chan, so a stream runs at one byte per clock while
// result_chan keeps up. The front end decodes the byte against the open
// sequence (remaining count and the payload gathered so far) and, when the
// byte causes results, writes one descriptor into a two-entry queue. The
// back end turns each descriptor into one item, or two items when a broken
// sequence is followed by a byte that itself gives a result; such a
// descriptor holds result_chan until both items are taken. Results arrive
// no sooner than the cycle after their byte is taken. A lead byte when idle
// and inner continuation bytes give no item at all. byte_chan.ready falls
// only when both queue entries are occupied. Overlong forms are not
// rejected, so code points span the full 31 bits; code_point is zero for
// invalid and end-of-string items, and last marks the final item of a byte.
// Reset is synchronous and clears the sequence state and the queue.
`include "utf8_byte_stream_decoder_core_macros.svh"

module utf8_byte_stream_decoder_core (
  input  logic          clk,
  input  logic          rst,
  ubsd_byte_if.sink     byte_chan,
  ubsd_result_if.source result_chan
);

  ubsd_pkg::push_t  push;
  ubsd_pkg::entry_t head;
  logic             head_valid;
  logic             full;
  logic             pop;

  ubsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_chan (byte_chan),
    .full      (full),
    .push      (push)
  );

  ubsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  ubsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .result_chan (result_chan)
  );

  // A non-final item is always the invalid report ahead of a second item.
  `UBSD_ASSERT_SAME(a_nonlast_is_invalid, result_chan.valid && !result_chan.last, result_chan.kind == ubsd_pkg::KIND_INVALID)
  // Once a non-final item is taken, the final item of the same byte follows.
  `UBSD_ASSERT_NEXT(a_second_follows, result_chan.valid && result_chan.ready && !result_chan.last, result_chan.valid && result_chan.last)
  // Only decoded characters carry a value.
  `UBSD_ASSERT_SAME(a_cp_zero, result_chan.valid && result_chan.kind != ubsd_pkg::KIND_CODE, result_chan.code_point == '0)
  // Input is held back only when results are waiting to be taken.
  `UBSD_ASSERT_SAME(a_stall_has_output, !byte_chan.ready, result_chan.valid)

endmodule
